// ----- src/xte_pkg.sv -----
// Shared types and constants for the XML text escape encoder.
// Used by xte_expand, xte_serializer and xml_text_escape_encoder; no dependencies.
package xte_pkg;

  localparam int BYTE_W  = 8;
  // Longest expansion: held "&#" released as "&amp;#" plus "&#xHH;".
  localparam int MAX_OUT = 12;
  localparam int LEN_W   = $clog2(MAX_OUT + 1);

  typedef logic [BYTE_W-1:0] byte_t;

  // Lookahead state between input bytes.
  typedef enum logic [1:0] {
    MODE_NORMAL,       // nothing held
    MODE_HELD_AMP,     // '&' held
    MODE_HELD_AMPHASH, // "&#" held
    MODE_RAW           // copying an existing reference up to its ';'
  } mode_t;

  // Output bytes caused by one input byte; bytes[0] goes out first.
  typedef struct packed {
    logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
    logic [LEN_W-1:0]               len;
    logic                           last;
  } seq_t;

endpackage

// ----- src/xte_expand.sv -----
// Combinational expansion of one input byte into its escaped output bytes.
// Depends on xte_pkg (mode_t, seq_t).
module xte_expand import xte_pkg::*; (
  input  mode_t mode,
  input  byte_t char_in,
  input  logic  last_in,
  output seq_t  seq,
  output mode_t mode_nxt
);

  typedef struct packed {
    logic [5:0][BYTE_W-1:0] txt;
    logic [2:0]             len;
  } esc_t;

  typedef enum logic [1:0] {PRE_NONE, PRE_AMP, PRE_AMPHASH} pre_sel_t;

  function automatic byte_t hex_digit(input logic [3:0] nib);
    byte_t d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h37 + {4'd0, nib};  // 'A' - 10
    end
    return d;
  endfunction

  function automatic esc_t escape_byte(input byte_t b);
    esc_t e;
    e.txt = '0;
    e.len = 3'd1;
    e.txt[0] = b;
    if (b == "&") begin
      e.txt = {8'h00, ";", "p", "m", "a", "&"};
      e.len = 3'd5;
    end else if (b == "<") begin
      e.txt = {8'h00, 8'h00, ";", "t", "l", "&"};
      e.len = 3'd4;
    end else if (b == ">") begin
      e.txt = {8'h00, 8'h00, ";", "t", "g", "&"};
      e.len = 3'd4;
    end else if (b == 8'h22) begin
      e.txt = {";", "t", "o", "u", "q", "&"};
      e.len = 3'd6;
    end else if (b == 8'h27) begin
      e.txt = {";", "s", "o", "p", "a", "&"};
      e.len = 3'd6;
    end else if (b < 8'd32) begin
      e.txt = {";", hex_digit(b[3:0]), hex_digit(b[7:4]), "x", "#", "&"};
      e.len = 3'd6;
    end
    return e;
  endfunction

  esc_t                   esc;
  logic                   hold_amp;
  pre_sel_t               pre_sel;
  logic [5:0][BYTE_W-1:0] body;
  logic [2:0]             body_len;
  logic [LEN_W-1:0]       pre_len;

  always_comb begin
    esc      = escape_byte(char_in);
    hold_amp = (char_in == "&") && !last_in;

    // Default: plain handling of the current byte
    pre_sel  = PRE_NONE;
    body     = esc.txt;
    body_len = hold_amp ? 3'd0 : esc.len;
    mode_nxt = hold_amp ? MODE_HELD_AMP : MODE_NORMAL;

    unique case (mode)
      MODE_NORMAL: begin
      end
      MODE_HELD_AMP: begin
        if ((char_in == "#") && !last_in) begin
          body_len = 3'd0;
          mode_nxt = MODE_HELD_AMPHASH;
        end else begin
          pre_sel = PRE_AMP;
        end
      end
      MODE_HELD_AMPHASH: begin
        if (char_in == "x") begin
          body     = {8'h00, 8'h00, 8'h00, "x", "#", "&"};
          body_len = 3'd3;
          mode_nxt = last_in ? MODE_NORMAL : MODE_RAW;
        end else begin
          pre_sel = PRE_AMPHASH;
        end
      end
      MODE_RAW: begin
        if (!((char_in == ";") || last_in)) begin
          body     = '0;
          body[0]  = char_in;
          body_len = 3'd1;
          mode_nxt = MODE_RAW;
        end
      end
    endcase

    // Released prefix first, then the body
    seq.bytes = '0;
    unique case (pre_sel)
      PRE_AMP: begin
        seq.bytes[4:0] = {";", "p", "m", "a", "&"};
        for (int i = 0; i < 6; i++) begin
          seq.bytes[i+5] = body[i];
        end
        pre_len = LEN_W'(5);
      end
      PRE_AMPHASH: begin
        seq.bytes[5:0] = {"#", ";", "p", "m", "a", "&"};
        for (int i = 0; i < 6; i++) begin
          seq.bytes[i+6] = body[i];
        end
        pre_len = LEN_W'(6);
      end
      default: begin
        seq.bytes[5:0] = body;
        pre_len = '0;
      end
    endcase
    seq.len  = pre_len + LEN_W'(body_len);
    seq.last = last_in;
  end

endmodule

// ----- src/xte_serializer.sv -----
// Result register: holds one expanded sequence and sends it a byte per transfer.
// Depends on xte_pkg (seq_t).
module xte_serializer import xte_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  seq_t  seq,
  output logic  free,
  output logic  out_tvalid,
  input  logic  out_tready,
  output byte_t out_tdata,
  output logic  out_tuser,
  output logic  out_tlast
);

  logic [MAX_OUT-1:0][BYTE_W-1:0] buf_r, buf_nxt;
  logic [LEN_W-1:0]               rem_r, rem_nxt;
  logic                           last_r, last_nxt;
  logic                           xfer;

  assign out_tvalid = (rem_r != '0);
  assign xfer       = out_tvalid && out_tready;
  assign out_tdata  = buf_r[0];
  assign out_tuser  = (rem_r == LEN_W'(1));
  assign out_tlast  = out_tuser && last_r;
  // Empty now, or the final byte leaves this cycle
  assign free       = !out_tvalid || (out_tuser && out_tready);

  always_comb begin
    buf_nxt  = buf_r;
    rem_nxt  = rem_r;
    last_nxt = last_r;
    if (load) begin
      buf_nxt  = seq.bytes;
      rem_nxt  = seq.len;
      last_nxt = seq.last;
    end else if (xfer) begin
      buf_nxt  = {{BYTE_W{1'b0}}, buf_r[MAX_OUT-1:1]};
      rem_nxt  = rem_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
    buf_r  <= buf_nxt;
    last_r <= last_nxt;
  end

endmodule

// ----- src/xml_text_escape_encoder.sv -----
// Top level of the XML text escape encoder: input register, lookahead mode
// register, expansion logic and result serializer. Depends on xte_pkg.
//
// Usage:
//   in_*  : one raw text byte per transfer (in_tdata), in_tlast on the final
//           byte of the string.
//   out_* : escaped text, one byte per transfer (out_tdata). out_tuser marks
//           the last byte caused by one input byte, out_tlast the final
//           byte of the whole string.
//   & < > " ' become entities, bytes below 0x20 become &#xHH;, an existing
//   "&#x" reference is copied raw up to its ';'. An '&' or "&#" is held
//   (no output) until the next byte decides; the final byte is never held.
// Path: an accepted byte goes through the input register, then the result
//   register, from which its output bytes are sent.
// Throughput: 1 byte per cycle while out_tready is high and each input yields
//   at most one output byte; an N-byte input (up to 12) occupies the result
//   register until all N are sent, the input register holding the next byte.
// Reset: rst_n low clears the held mode to normal and empties both stages.
// Stall: with out_tready low the result register and the input register
//   hold; in_tready drops once the input register is occupied.
module xml_text_escape_encoder import xte_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  byte_t in_tdata,    // [7:0] char_in
  input  logic  in_tlast,    // last_in
  output logic  out_tvalid,
  input  logic  out_tready,
  output byte_t out_tdata,   // [7:0] char_out
  output logic  out_tuser,   // [0] run_end
  output logic  out_tlast    // text_end
);

  logic  in_valid_r, in_valid_nxt;
  byte_t in_char_r;
  logic  in_last_r;
  mode_t mode_r, mode_nxt;
  seq_t  seq;
  logic  free;
  logic  load;
  logic  in_xfer;

  // Expansion of the registered byte against the current mode
  xte_expand u_expand (
    .mode     (mode_r),
    .char_in  (in_char_r),
    .last_in  (in_last_r),
    .seq      (seq),
    .mode_nxt (mode_nxt)
  );

  // Move the registered byte into the result register when it frees up
  assign load      = in_valid_r && free;
  assign in_tready = !in_valid_r || load;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (load) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      mode_r     <= MODE_NORMAL;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (load) begin
        mode_r <= mode_nxt;
      end
    end
    if (in_xfer) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  xte_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .seq        (seq),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A string's final byte always produces output and clears the lookahead
  a_last_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    load && in_last_r |-> seq.len != '0)
    else $error("final byte expanded to nothing");

  a_last_clears_mode: assert property (@(posedge clk) disable iff (!rst_n)
    load && in_last_r |=> mode_r == MODE_NORMAL)
    else $error("lookahead mode left set after end of string");

  // A byte waiting in the input register is not dropped or altered
  a_held_input_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !free |=> in_valid_r && $stable(in_char_r) && $stable(in_last_r))
    else $error("pending input byte lost");

  a_tlast_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("end of string not on last byte of a run");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> seq.len <= LEN_W'(MAX_OUT))
    else $error("expansion longer than result register");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for xml_text_escape_encoder: directed and random text strings
// are streamed in, and each escaped output byte is checked against a local predictor.
// Depends on xte_pkg and the xml_text_escape_encoder RTL.
module tb;
  import xte_pkg::*;

  // Bytes with a special meaning to the escaper
  localparam byte_t CH_AMP  = 8'h26;
  localparam byte_t CH_LT   = 8'h3C;
  localparam byte_t CH_GT   = 8'h3E;
  localparam byte_t CH_QUOT = 8'h22;
  localparam byte_t CH_APOS = 8'h27;
  localparam byte_t CH_HASH = 8'h23;
  localparam byte_t CH_X    = 8'h78;
  localparam byte_t CH_SEMI = 8'h3B;
  localparam byte_t CH_CTL_LIMIT = 8'h20;

  localparam int LIMIT_TIME = 20_000_000;

  // One escaped output byte as it should appear on out_*
  typedef struct {
    byte_t ch;
    logic  run_end;
    logic  text_end;
  } esc_byte_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_tvalid = 1'b0;
  logic  in_tready;
  byte_t in_tdata = '0;
  logic  in_tlast = 1'b0;
  logic  out_tvalid;
  logic  out_tready = 1'b0;
  byte_t out_tdata;
  logic  out_tuser;
  logic  out_tlast;

  xml_text_escape_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // Predictor state and the store of escaped bytes still to arrive
  mode_t     esc_mode = MODE_NORMAL;
  byte_t     step_bytes[$];
  esc_byte_t escaped_q[$];

  int n_in      = 0;
  int n_strings = 0;
  int n_out     = 0;
  int n_err     = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  function automatic byte_t hex_digit(input logic [3:0] d);
    return (d < 4'd10) ? 8'h30 + byte_t'(d) : 8'h37 + byte_t'(d);
  endfunction

  function automatic void emit_str(input string s);
    for (int i = 0; i < s.len(); i++) step_bytes.push_back(byte_t'(s[i]));
  endfunction

  function automatic void emit_escaped(input byte_t c);
    case (c)
      CH_AMP:  emit_str("&amp;");
      CH_LT:   emit_str("&lt;");
      CH_GT:   emit_str("&gt;");
      CH_QUOT: emit_str("&quot;");
      CH_APOS: emit_str("&apos;");
      default: begin
        if (c < CH_CTL_LIMIT) begin
          emit_str("&#x");
          step_bytes.push_back(hex_digit(c[7:4]));
          step_bytes.push_back(hex_digit(c[3:0]));
          step_bytes.push_back(CH_SEMI);
        end else begin
          step_bytes.push_back(c);
        end
      end
    endcase
  endfunction

  // Plain handling; a non-final '&' is held for lookahead
  function automatic void escape_plain(input byte_t c, input logic l);
    if (c == CH_AMP && !l) begin
      esc_mode = MODE_HELD_AMP;
    end else begin
      esc_mode = MODE_NORMAL;
      emit_escaped(c);
    end
  endfunction

  // Works out the output bytes of one accepted input byte and queues them
  function automatic void predict_escape(input byte_t c, input logic l);
    esc_byte_t e;
    step_bytes.delete();
    case (esc_mode)
      MODE_HELD_AMP: begin
        if (c == CH_HASH && !l) begin
          esc_mode = MODE_HELD_AMPHASH;
        end else begin
          emit_str("&amp;");
          escape_plain(c, l);
        end
      end
      MODE_HELD_AMPHASH: begin
        if (c == CH_X) begin
          emit_str("&#x");
          esc_mode = l ? MODE_NORMAL : MODE_RAW;
        end else begin
          emit_str("&amp;");
          step_bytes.push_back(CH_HASH);
          escape_plain(c, l);
        end
      end
      MODE_RAW: begin
        if (c == CH_SEMI || l) escape_plain(c, l);
        else step_bytes.push_back(c);
      end
      default: escape_plain(c, l);
    endcase
    for (int i = 0; i < step_bytes.size(); i++) begin
      e.ch       = step_bytes[i];
      e.run_end  = (i == step_bytes.size() - 1);
      e.text_end = e.run_end && l;
      escaped_q.push_back(e);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    n_err++;
  endtask

  // Drives one byte at the falling edge, waits for its transfer, then predicts it
  task automatic send_char(input byte_t c, input logic l);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_escape(c, l);
    n_in++;
    if (l) n_strings++;
  endtask

  task automatic send_string(input byte_t s[$]);
    for (int i = 0; i < s.size(); i++) send_char(s[i], i == s.size() - 1);
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Output checker: every output transfer against the oldest expectation
  always @(posedge clk) begin
    esc_byte_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_out++;
      if (escaped_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_tdata));
      end else begin
        e = escaped_q.pop_front();
        if (out_tdata !== e.ch)
          report_mismatch($sformatf("char_out %02h, want %02h", out_tdata, e.ch));
        if (out_tuser !== e.run_end)
          report_mismatch($sformatf("run_end %b, want %b (byte %02h)",
                                    out_tuser, e.run_end, e.ch));
        if (out_tlast !== e.text_end)
          report_mismatch($sformatf("text_end %b, want %b (byte %02h)",
                                    out_tlast, e.text_end, e.ch));
      end
    end
  end

  // The five entities, then a held '&' released by an ordinary final byte
  task automatic test_entities();
    send_string('{CH_LT, CH_GT, CH_QUOT, CH_APOS, CH_AMP, 8'h41});
  endtask

  // Control-byte extremes, the first printable byte, both ends of the high range
  task automatic test_control_and_high();
    send_string('{8'h00, 8'h1F, 8'h20, 8'h80, 8'hFF});
  endtask

  // Existing references and the broken or truncated prefixes
  task automatic test_char_refs();
    // well-formed reference copied raw
    send_string('{CH_AMP, CH_HASH, CH_X, 8'h34, 8'h31, CH_SEMI});
    // "&#" not followed by 'x', then "&&", then "&#x" ending the string
    send_string('{CH_AMP, CH_HASH, 8'h71, CH_AMP, CH_AMP, CH_HASH, CH_X});
    // '&' alone as the final byte, and "&#" with '#' final
    send_string('{CH_AMP});
    send_string('{CH_AMP, CH_HASH});
    // reference without ';' closed by the final byte, which is a control byte
    send_string('{CH_AMP, CH_HASH, CH_X, 8'h7A, 8'h05});
  endtask

  // Random strings, most built from well-formed pieces, some broken
  task automatic test_random_strings(input int n_items);
    int    start;
    int    target;
    int    r;
    int    n_hex;
    byte_t s[$];
    start = n_in;
    while (n_in - start < n_items) begin
      s.delete();
      target = $urandom_range(1, 16);
      while (s.size() < target) begin
        r = $urandom_range(99);
        if (r < 35) begin
          s.push_back(byte_t'($urandom_range(32, 126)));
        end else if (r < 50) begin
          case ($urandom_range(4))
            0: s.push_back(CH_AMP);
            1: s.push_back(CH_LT);
            2: s.push_back(CH_GT);
            3: s.push_back(CH_QUOT);
            default: s.push_back(CH_APOS);
          endcase
        end else if (r < 60) begin
          s.push_back(byte_t'($urandom_range(0, 31)));
        end else if (r < 70) begin
          s.push_back(byte_t'($urandom_range(128, 255)));
        end else if (r < 90) begin
          // reference: mostly hex digits, sometimes any byte, usually closed
          s.push_back(CH_AMP);
          s.push_back(CH_HASH);
          s.push_back(CH_X);
          n_hex = $urandom_range(1, 4);
          repeat (n_hex) begin
            if ($urandom_range(9) == 0) s.push_back(byte_t'($urandom_range(0, 255)));
            else s.push_back(hex_digit(4'($urandom_range(15))));
          end
          if ($urandom_range(99) < 85) s.push_back(CH_SEMI);
        end else begin
          // broken prefix followed by anything
          s.push_back(CH_AMP);
          if ($urandom_range(1)) s.push_back(CH_HASH);
          s.push_back(byte_t'($urandom_range(0, 255)));
        end
      end
      // pieces may overrun the target; the cut can land inside a reference
      while (s.size() > target) void'(s.pop_back());
      send_string(s);
    end
  endtask

  task automatic set_idling(input int snd_pct, input int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_idling(25, 47);
    test_entities();
    test_control_and_high();
    test_char_refs();
    test_random_strings(160);

    set_idling(47, 25);
    test_random_strings(160);

    set_idling(0, 0);
    test_random_strings(160);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d strings; checked %0d escaped output bytes.",
             n_in, n_strings, n_out);
    $display("Covered entities, control and high bytes, raw references, broken prefixes.");
    if (n_err == 0 && escaped_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #LIMIT_TIME;
    $display("Timeout with %0d bytes still expected.", escaped_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
